// ----- hw/rtl/bdq_pkg.sv -----
// Shared types and operation/status codes for the bounded deque.
package bdq_pkg;

    typedef logic        [2:0]  t_op;
    typedef logic        [1:0]  t_status;
    typedef logic signed [31:0] t_value;
    typedef logic        [3:0]  t_index;
    typedef logic        [4:0]  t_size;

    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_BACK  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_BACK   = 3'd3;
    localparam t_op OP_READ       = 3'd4;
    localparam t_op OP_REMOVE     = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_RANGE = 2'd3;

endpackage

// ----- hw/rtl/bdq_in_if.sv -----
// Request channel of the bounded deque: operation, value and index.
interface bdq_in_if;
    logic              valid;
    logic              ready;
    bdq_pkg::t_op      operation;
    bdq_pkg::t_value   value;
    bdq_pkg::t_index   index;

    modport source (output valid, output operation, output value, output index, input ready);
    modport sink   (input valid, input operation, input value, input index, output ready);
endinterface

// ----- hw/rtl/bdq_out_if.sv -----
// Response channel of the bounded deque: value, status and count after the operation.
interface bdq_out_if;
    logic              valid;
    logic              ready;
    bdq_pkg::t_value   result_value;
    bdq_pkg::t_status  status;
    bdq_pkg::t_size    size_after;

    modport source (output valid, output result_value, output status, output size_after,
                    input ready);
    modport sink   (input valid, input result_value, input status, input size_after,
                    output ready);
endinterface

// ----- hw/rtl/bounded_deque_with_value_removal.sv -----
// Bounded deque top level: ring memory, sequencer and result register.
//
// The deque holds up to DEPTH 32-bit entries in a single-port ring memory
// with registered read data; one ring-position adder (front plus offset,
// wrapped modulo DEPTH) serves every access. One request is handled at a
// time and the request side is ready only while the sequencer is idle.
// Push, error cases and unused codes go from accept straight to the done
// state; pop and read pass through a data state for the registered memory
// read; remove-all walks every entry with one read and at most one write
// through the same memory port. The result sits in its own register, so a
// new request is taken while a response waits.
module bounded_deque_with_value_removal #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_in_if.sink    i_req,
    bdq_out_if.source o_rsp
);
    import bdq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDATA  = 3'd1;
    localparam logic [2:0] S_RM_RD  = 3'd2;
    localparam logic [2:0] S_RM_CMP = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_wr, n_wr;
    t_op           r_op, n_op;
    t_value        r_val, n_val;
    t_value        r_res, n_res;
    t_status       r_st, n_st;
    t_value        r_rdata;

    logic          r_out_valid;
    t_value        r_out_res;
    t_status       r_out_st;
    t_size         r_out_size;

    logic [31:0]   mem [DEPTH];
    logic          mem_we;
    logic          mem_re;
    logic [31:0]   mem_wdata;

    // shared ring-position unit
    logic [AW-1:0] ring_off;
    logic [AW:0]   ring_sum;
    logic [AW-1:0] ring_pos;

    logic          accept;
    logic          full;
    logic          empty;
    logic          out_free;

    assign accept   = i_req.valid && i_req.ready;
    assign full     = r_count >= CW'(DEPTH);
    assign empty    = r_count == '0;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign ring_sum = {1'b0, r_front} + {1'b0, ring_off};
    assign ring_pos = (ring_sum >= (AW+1)'(DEPTH)) ? AW'(ring_sum - (AW+1)'(DEPTH))
                                                  : AW'(ring_sum);

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_op      = r_op;
        n_val     = r_val;
        n_res     = r_res;
        n_st      = r_st;
        ring_off  = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = r_rdata;

        case (r_state)
            S_IDLE: begin
                case (i_req.operation)
                    OP_PUSH_FRONT: ring_off = AW'(DEPTH - 1);
                    OP_PUSH_BACK:  ring_off = AW'(r_count);
                    OP_POP_BACK:   ring_off = AW'(r_count - 1'b1);
                    OP_READ:       ring_off = AW'(i_req.index);
                    default:       ring_off = '0;
                endcase
                mem_wdata = i_req.value;
                if (accept) begin
                    n_op  = i_req.operation;
                    n_val = i_req.value;
                    n_res = '0;
                    n_st  = ST_OK;
                    n_state = S_DONE;
                    case (i_req.operation)
                        OP_PUSH_FRONT: begin
                            if (full) begin
                                n_st = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_front = ring_pos;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (full) begin
                                n_st = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            if (empty) begin
                                n_st = ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_RDATA;
                            end
                        end
                        OP_READ: begin
                            if (CMPW'(i_req.index) >= CMPW'(r_count)) begin
                                n_st = ST_RANGE;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_RDATA;
                            end
                        end
                        OP_REMOVE: begin
                            n_rd    = '0;
                            n_wr    = '0;
                            n_state = S_RM_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_RDATA: begin
                ring_off = AW'(1);
                n_res    = r_rdata;
                n_state  = S_DONE;
                case (r_op)
                    OP_POP_FRONT: begin
                        n_front = ring_pos;
                        n_count = r_count - 1'b1;
                    end
                    OP_POP_BACK: n_count = r_count - 1'b1;
                    default:     n_count = r_count;
                endcase
            end
            S_RM_RD: begin
                ring_off = AW'(r_rd);
                if (r_rd == r_count) begin
                    n_count = r_wr;
                    n_state = S_DONE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                // compact: keep the entry at the write position unless it matches
                ring_off = AW'(r_wr);
                if (r_rdata != r_val) begin
                    mem_we = 1'b1;
                    n_wr   = r_wr + 1'b1;
                end
                n_rd    = r_rd + 1'b1;
                n_state = S_RM_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= n_rd;
        r_wr  <= n_wr;
        r_op  <= n_op;
        r_val <= n_val;
        r_res <= n_res;
        r_st  <= n_st;
        if (r_state == S_DONE && out_free) begin
            r_out_res  <= r_res;
            r_out_st   <= r_st;
            r_out_size <= t_size'(r_count);
        end
    end

    // ring memory: one access per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[ring_pos] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[ring_pos];
        end
    end

    assign i_req.ready        = r_state == S_IDLE;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_res;
    assign o_rsp.status       = r_out_st;
    assign o_rsp.size_after   = r_out_size;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_rdata_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDATA) |-> (r_count != '0))
        else $error("pop or read data phase on an empty deque");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RM_RD || r_state == S_RM_CMP) |-> (r_wr <= r_rd && r_rd <= r_count))
        else $error("removal write position ran ahead of read position");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !full && (i_req.operation == OP_PUSH_FRONT
                             || i_req.operation == OP_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the deque");

endmodule

// ----- tb/sv/bounded_deque_with_value_removal_tb.sv -----
// Self-checking testbench for the bounded deque with value removal.
module bounded_deque_with_value_removal_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_OPS   = 550;

    // Codes the block treats as no operation.
    localparam t_op OP_UNUSED_LO = 3'd6;
    localparam t_op OP_UNUSED_HI = 3'd7;

    typedef enum {BIAS_FILL, BIAS_DRAIN, BIAS_MIXED} fill_bias_e;

    typedef struct {
        t_op    operation;
        t_value value;
        t_index index;
    } deque_op_t;

    typedef struct {
        t_value  result_value;
        t_status status;
        t_size   size_after;
    } deque_rsp_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bdq_in_if  req_if ();
    bdq_out_if rsp_if ();

    bounded_deque_with_value_removal #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    deque_op_t  pending_ops [$];
    deque_rsp_t results_due [$];

    // Shadow copy of the deque contents.
    t_value      shadow_mem [DEPTH];
    int unsigned shadow_front = 0;
    int unsigned shadow_count = 0;

    int          mismatch_count = 0;
    int          rsp_seen = 0;
    int unsigned cycle_count = 0;

    int          burst_left;
    int          idle_left;
    deque_op_t   next_op;
    int          stall_mode;
    int unsigned stall_cycle;
    deque_op_t   accepted_op;
    deque_rsp_t  due;

    function automatic deque_rsp_t deque_apply_op(deque_op_t r);
        deque_rsp_t  rsp;
        int unsigned wr;
        t_value      e;
        rsp.result_value = '0;
        rsp.status       = ST_OK;
        case (r.operation)
            OP_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                    shadow_mem[shadow_front] = r.value;
                    shadow_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    shadow_mem[(shadow_front + shadow_count) % DEPTH] = r.value;
                    shadow_count++;
                end
            end
            OP_POP_FRONT: begin
                if (shadow_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.result_value = shadow_mem[shadow_front];
                    shadow_front = (shadow_front + 1) % DEPTH;
                    shadow_count--;
                end
            end
            OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.result_value = shadow_mem[(shadow_front + shadow_count - 1) % DEPTH];
                    shadow_count--;
                end
            end
            OP_READ: begin
                if (r.index >= shadow_count) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.result_value = shadow_mem[(shadow_front + r.index) % DEPTH];
                end
            end
            OP_REMOVE: begin
                // Compact the survivors toward the front, keeping their order.
                wr = 0;
                for (int rd = 0; rd < shadow_count; rd++) begin
                    e = shadow_mem[(shadow_front + rd) % DEPTH];
                    if (e != r.value) begin
                        shadow_mem[(shadow_front + wr) % DEPTH] = e;
                        wr++;
                    end
                end
                shadow_count = wr;
            end
            default: begin
            end
        endcase
        rsp.size_after = t_size'(shadow_count);
        return rsp;
    endfunction

    function automatic void queue_op(t_op op, t_value val, t_index idx);
        deque_op_t item;
        item.operation = op;
        item.value     = val;
        item.index     = idx;
        pending_ops.push_back(item);
    endfunction

    // Mostly a small pool so that removal finds matches; the rest spans all bits.
    function automatic t_value random_value();
        if ($urandom_range(0, 9) < 6) begin
            return t_value'($urandom_range(0, 7)) - 3;
        end
        return t_value'($urandom());
    endfunction

    function automatic void queue_random_op(fill_bias_e bias);
        int unsigned cut [5];
        int unsigned pick;
        t_op         op;
        case (bias)
            BIAS_FILL:  cut = '{30, 60, 70, 78, 90};
            BIAS_DRAIN: cut = '{10, 20, 45, 70, 85};
            default:    cut = '{20, 40, 53, 66, 83};
        endcase
        pick = $urandom_range(0, 99);
        if (pick < cut[0]) begin
            op = OP_PUSH_FRONT;
        end else if (pick < cut[1]) begin
            op = OP_PUSH_BACK;
        end else if (pick < cut[2]) begin
            op = OP_POP_FRONT;
        end else if (pick < cut[3]) begin
            op = OP_POP_BACK;
        end else if (pick < cut[4]) begin
            op = OP_READ;
        end else if (pick < 97) begin
            op = OP_REMOVE;
        end else begin
            op = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
        end
        queue_op(op, random_value(), t_index'($urandom_range(0, 15)));
    endfunction

    // Request driver: bursts of transactions separated by random idle gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            burst_left   <= $urandom_range(1, 12);
            idle_left    <= 0;
        end else if (!req_if.valid || req_if.ready) begin
            if (idle_left > 0 || pending_ops.size() == 0) begin
                req_if.valid <= 1'b0;
                if (idle_left > 0) begin
                    idle_left <= idle_left - 1;
                end
            end else begin
                next_op = pending_ops.pop_front();
                req_if.valid     <= 1'b1;
                req_if.operation <= next_op.operation;
                req_if.value     <= next_op.value;
                req_if.index     <= next_op.index;
                if (burst_left <= 1) begin
                    // Now and then a long burst with no gap at all.
                    burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                              : $urandom_range(1, 12);
                    idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Response sink: stall pattern drawn at random from four modes and redrawn during the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_mode   <= 0;
            stall_cycle  <= 0;
        end else begin
            stall_cycle <= stall_cycle + 1;
            if (stall_cycle % 97 == 0) begin
                stall_mode <= $urandom_range(0, 3);
            end
            case (stall_mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= $urandom_range(0, 1);
                2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_if.ready <= (stall_cycle % 7 >= 3);
            endcase
        end
    end

    // Check responses first, then predict the transaction accepted at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_seen++;
                if (results_due.size() == 0) begin
                    $display("%0t: response %0d with nothing outstanding: value %0d status %0d size %0d",
                             $time, rsp_seen, rsp_if.result_value, rsp_if.status,
                             rsp_if.size_after);
                    mismatch_count++;
                end else begin
                    due = results_due.pop_front();
                    if (rsp_if.result_value !== due.result_value) begin
                        $display("%0t: response %0d result_value: expected %0d, actual %0d",
                                 $time, rsp_seen, due.result_value, rsp_if.result_value);
                        mismatch_count++;
                    end
                    if (rsp_if.status !== due.status) begin
                        $display("%0t: response %0d status: expected %0d, actual %0d",
                                 $time, rsp_seen, due.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.size_after !== due.size_after) begin
                        $display("%0t: response %0d size_after: expected %0d, actual %0d",
                                 $time, rsp_seen, due.size_after, rsp_if.size_after);
                        mismatch_count++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                accepted_op.operation = req_if.operation;
                accepted_op.value     = req_if.value;
                accepted_op.index     = req_if.index;
                results_due.push_back(deque_apply_op(accepted_op));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run did not complete, %0d responses outstanding",
                     $time, results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int          done;
        fill_bias_e  bias;
        int          span;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_PUSH_FRONT;
        req_if.value     = '0;
        req_if.index     = '0;
        rsp_if.ready     = 1'b0;

        // Empty queue: pops, reads and removal, plus the unused codes.
        queue_op(OP_POP_FRONT, 32'sd0, 4'd0);
        queue_op(OP_POP_BACK, 32'sd0, 4'd0);
        queue_op(OP_READ, 32'sd0, 4'd0);
        queue_op(OP_READ, 32'sd0, 4'd15);
        queue_op(OP_REMOVE, 32'sd0, 4'd0);
        queue_op(OP_UNUSED_LO, 32'sd1, 4'd1);
        queue_op(OP_UNUSED_HI, -32'sd1, 4'd15);
        // Value extremes at both ends.
        queue_op(OP_PUSH_FRONT, t_value'(32'h8000_0000), 4'd0);
        queue_op(OP_PUSH_BACK, t_value'(32'h7fff_ffff), 4'd0);
        queue_op(OP_PUSH_FRONT, 32'sd0, 4'd0);
        queue_op(OP_PUSH_BACK, -32'sd1, 4'd0);
        // Fill to capacity, half of these pushes holding the value removed below.
        for (int i = 0; i < DEPTH - 4; i++) begin
            queue_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                     (i % 2) ? 32'sd5 : t_value'(i), 4'd0);
        end
        queue_op(OP_PUSH_FRONT, 32'sd9, 4'd0);
        queue_op(OP_PUSH_BACK, 32'sd9, 4'd0);
        queue_op(OP_READ, 32'sd0, 4'd15);
        queue_op(OP_REMOVE, 32'sd5, 4'd0);
        queue_op(OP_READ, 32'sd0, 4'd10);
        queue_op(OP_POP_BACK, 32'sd0, 4'd0);

        // Random phases that lean toward filling, draining or neither.
        done = 0;
        while (done < RANDOM_OPS) begin
            bias = fill_bias_e'($urandom_range(0, 2));
            span = $urandom_range(10, 40);
            for (int i = 0; i < span; i++) begin
                queue_random_op(bias);
            end
            done += span;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req_if.valid) @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
